// ===== design/abp_pkg.sv =====
// Shared types and constants for the affine bit permuter.
// No dependencies; used by affine_bit_permuter.
package abp_pkg;

    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 7;
    localparam int unsigned MULT_BITS      = 6;
    localparam int unsigned OFFSET_BITS    = 6;
    localparam int unsigned WIDTH_BITS     = 7;
    localparam int unsigned DATA_BITS      = 64;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MULTIPLIER = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH      = 2'd2;

    localparam logic [MULT_BITS-1:0]  ROTATE_SELECT   = 6'd10;
    localparam logic [MULT_BITS-1:0]  MULT_RESET      = 6'd1;
    localparam logic [OFFSET_BITS-1:0] OFFSET_RESET   = 6'd0;
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET     = 7'd64;

    localparam logic REQ_FORWARD = 1'b0;
    localparam logic REQ_INVERSE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_P,
        ST_RED_Q,
        ST_RUN,
        ST_FINISH
    } abp_state_t;

endpackage

// ===== design/abp_mod_adder.sv =====
// Shared modular adder: (a + b) mod m for a < m and b <= m.
// Depends on nothing; instantiated once by affine_bit_permuter.
module abp_mod_adder #(
    parameter int unsigned N = 7
) (
    input  logic [N-1:0] a,
    input  logic [N-1:0] b,
    input  logic [N-1:0] m,
    output logic [N-1:0] sum
);

    logic [N:0] raw;
    logic [N:0] diff;

    always_comb
    begin
        raw  = {1'b0, a} + {1'b0, b};
        diff = raw - {1'b0, m};
        if (raw >= {1'b0, m})
        begin
            sum = diff[N-1:0];
        end
        else
        begin
            sum = raw[N-1:0];
        end
    end

endmodule

// ===== design/affine_bit_permuter.sv =====
// Top level of the affine bit permuter: sequencer, bit registers and ports.
// Depends on abp_pkg and abp_mod_adder.

// A request passes through the sequencer to the output register: it reduces
// the multiplier mod w bit by bit, then the offset mod w likewise, then walks
// one field position per cycle, and last loads the output register; a field
// width of zero goes straight to the load. The single modular adder serves
// both reductions and the walk. in_ready is high only while the sequencer is
// idle; a finished result waits in the output register, and the next request
// is taken meanwhile. The inverse map is applied as a scatter of the forward
// index map, except that a forward request with the multiplier at ROTATE_SELECT
// steps by one; a repeated target position flags the multiplier as not
// invertible. Configuration registers are written through the cfg channel,
// which is always ready, and must only be written while no request is open.
module affine_bit_permuter #(
    parameter int unsigned WORD_BITS = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [abp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [abp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [abp_pkg::DATA_BITS-1:0]      data_word,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [abp_pkg::DATA_BITS-1:0]      result_word,
    output logic                               invalid
);

    import abp_pkg::*;

    localparam int unsigned IDX_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int unsigned NW    = $clog2(WORD_BITS + 1);
    localparam int unsigned CW    = (NW > 3) ? NW : 3;

    abp_state_t state_reg, state_next;

    logic [MULT_BITS-1:0]   mult_reg, mult_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [WIDTH_BITS-1:0]  width_reg, width_next;

    logic [WORD_BITS-1:0]   word_reg, word_next;
    logic [WORD_BITS-1:0]   res_reg, res_next;
    logic                   inv_reg, inv_next;
    logic                   bad_reg, bad_next;
    logic [MULT_BITS-1:0]   sh_reg, sh_next;
    logic [IDX_W-1:0]       cur_reg, cur_next;
    logic [IDX_W-1:0]       step_reg, step_next;
    logic [IDX_W-1:0]       qmod_reg, qmod_next;
    logic [CW-1:0]          cnt_reg, cnt_next;

    logic                   out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0]   out_word_reg, out_word_next;
    logic                   out_inv_reg, out_inv_next;

    logic [NW-1:0]          w_eff;
    logic [NW-1:0]          add_a;
    logic [NW-1:0]          add_b;
    logic [NW-1:0]          add_sum;
    logic [IDX_W-1:0]       add_res;
    logic                   in_fire;
    logic                   red_last;
    logic                   run_last;
    logic                   slot_free;
    logic [IDX_W-1:0]       pos_cnt;
    logic [IDX_W-1:0]       bit_cnt;
    logic [IDX_W-1:0]       bit_cur;

    abp_mod_adder #(
        .N (NW)
    ) u_mod_adder (
        .a   (add_a),
        .b   (add_b),
        .m   (w_eff),
        .sum (add_sum)
    );

    assign w_eff     = (width_reg > WIDTH_BITS'(WORD_BITS)) ? NW'(WORD_BITS)
                                                            : width_reg[NW-1:0];
    assign add_res   = add_sum[IDX_W-1:0];
    assign in_fire   = in_valid && in_ready;
    assign red_last  = (cnt_reg == CW'(5));
    assign run_last  = (cnt_reg == (CW'(w_eff) - CW'(1)));
    assign slot_free = !out_valid_reg || out_ready;
    assign pos_cnt   = cnt_reg[IDX_W-1:0];
    assign bit_cnt   = IDX_W'(WORD_BITS - 1) - pos_cnt;
    assign bit_cur   = IDX_W'(WORD_BITS - 1) - cur_reg;

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign result_word = DATA_BITS'(out_word_reg);
    assign invalid     = out_inv_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_RED_P, ST_RED_Q:
            begin
                add_a = NW'(cur_reg);
                add_b = NW'(cur_reg) + NW'(sh_reg[MULT_BITS-1]);
            end
            default:
            begin
                add_a = NW'(cur_reg);
                add_b = NW'(step_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (w_eff == '0) ? ST_FINISH : ST_RED_P;
                end
            end
            ST_RED_P:
            begin
                if (red_last)
                begin
                    state_next = ST_RED_Q;
                end
            end
            ST_RED_Q:
            begin
                if (red_last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (run_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
    end

    always_comb
    begin
        mult_next   = mult_reg;
        offset_next = offset_reg;
        width_next  = width_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MULTIPLIER: mult_next   = cfg_data[MULT_BITS-1:0];
                CFG_OFFSET:     offset_next = cfg_data[OFFSET_BITS-1:0];
                CFG_WIDTH:      width_next  = cfg_data[WIDTH_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        word_next      = word_reg;
        res_next       = res_reg;
        inv_next       = inv_reg;
        bad_next       = bad_reg;
        sh_next        = sh_reg;
        cur_next       = cur_reg;
        step_next      = step_reg;
        qmod_next      = qmod_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        out_inv_next   = out_inv_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    word_next = data_word[WORD_BITS-1:0];
                    res_next  = data_word[WORD_BITS-1:0];
                    inv_next  = req_type;
                    bad_next  = 1'b0;
                    sh_next   = mult_reg;
                    cur_next  = '0;
                    cnt_next  = '0;
                end
            end
            ST_RED_P:
            begin
                cur_next = add_res;
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg + CW'(1);
                if (red_last)
                begin
                    if ((inv_reg == REQ_FORWARD) && (mult_reg == ROTATE_SELECT))
                    begin
                        step_next = IDX_W'(1);
                    end
                    else
                    begin
                        step_next = add_res;
                    end
                    sh_next  = offset_reg;
                    cur_next = '0;
                    cnt_next = '0;
                end
            end
            ST_RED_Q:
            begin
                cur_next = add_res;
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg + CW'(1);
                if (red_last)
                begin
                    qmod_next = add_res;
                    cnt_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (inv_reg == REQ_INVERSE)
                begin
                    res_next[bit_cur] = word_reg[bit_cnt];
                    if ((cnt_reg != '0) && (cur_reg == qmod_reg))
                    begin
                        bad_next = 1'b1;
                    end
                end
                else
                begin
                    res_next[bit_cnt] = word_reg[bit_cur];
                end
                cur_next = add_res;
                cnt_next = cnt_reg + CW'(1);
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_inv_next   = (inv_reg == REQ_INVERSE) && bad_reg;
                    out_word_next  = ((inv_reg == REQ_INVERSE) && bad_reg) ? word_reg
                                                                            : res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mult_reg      <= MULT_RESET;
            offset_reg    <= OFFSET_RESET;
            width_reg     <= WIDTH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mult_reg      <= mult_next;
            offset_reg    <= offset_next;
            width_reg     <= width_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        res_reg      <= res_next;
        inv_reg      <= inv_next;
        bad_reg      <= bad_next;
        sh_reg       <= sh_next;
        cur_reg      <= cur_next;
        step_reg     <= step_next;
        qmod_reg     <= qmod_next;
        cnt_reg      <= cnt_next;
        out_word_reg <= out_word_next;
        out_inv_reg  <= out_inv_next;
    end

endmodule
